// ===== sv/mswg_pkg.sv =====
// ---------------------------------------------------------------------------
// mswg_pkg
// Shared constants, types and the quarter-wave sine table builder for the
// multi-shape waveform generator.
// ---------------------------------------------------------------------------
package mswg_pkg;

  // Default sizes
  localparam int DEF_PHASE_BITS      = 32;
  localparam int DEF_SINE_TABLE_BITS = 10;

  // Output sample range; saturation limit is +-(2^(SAMPLE_BITS-1) - 1)
  localparam int          SAMPLE_BITS  = 16;
  localparam int          SAMPLE_W     = 16;
  localparam logic [31:0] SAMPLE_LIMIT = 32'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

  // Register map (index = paddr[3:2])
  localparam int         ADDR_W         = 4;
  localparam logic [1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [1:0] REG_AMPLITUDE  = 2'd1;
  localparam logic [1:0] REG_WAVE_SHAPE = 2'd2;

  // Register reset values
  localparam logic [31:0] RST_PHASE_STEP = 32'd4869566;
  localparam logic [14:0] RST_AMPLITUDE  = 15'd30000;
  localparam logic [1:0]  RST_WAVE_SHAPE = 2'd0;

  // Wave shape codes
  localparam logic [1:0] SHAPE_SINE     = 2'd0;
  localparam logic [1:0] SHAPE_SQUARE   = 2'd1;
  localparam logic [1:0] SHAPE_SAWTOOTH = 2'd2;
  localparam logic [1:0] SHAPE_TRIANGLE = 2'd3;

  // Magnitude (Q1.32) times amplitude
  localparam int MAG_W  = 33;
  localparam int AMP_W  = 15;
  localparam int PROD_W = MAG_W + AMP_W;
  localparam int TAB_W  = 15;

  typedef struct packed {
    logic              neg;
    logic [PROD_W-1:0] mag;
  } prod_t;

  // Table builder constants (elaboration only)
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SIN_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210, 64'd272};

  // One entry of the quarter-wave table, Q1.15, clamped to 32767.
  // sin() by a 9-term Taylor series in Q30.
  function automatic logic [TAB_W-1:0] sine_entry(input int unsigned idx,
                                                   input int unsigned tbits);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint          q;
    x    = (HALF_PI_Q30 * longint'(idx)) >> tbits;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / SIN_DIV[k-1];
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    q = (sum + 64'sd16384) >>> 15;
    if (q > 64'sd32767) begin
      q = 64'sd32767;
    end
    return q[TAB_W-1:0];
  endfunction

endpackage

// ===== sv/multi_shape_waveform_generator.sv =====
// ---------------------------------------------------------------------------
// multi_shape_waveform_generator
// Direct digital synthesis source: one signed sample per tick item, in sine,
// square, sawtooth or triangle shape, set up through an APB register port.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------
//   tick     | tick_valid / tick_stall    | restart (1)
//   sample   | sample_valid / sample_stall| sample (16, signed)
//   config   | psel/penable/pwrite/pready | paddr (4), pwdata/prdata (32)
//
// One tick item per clock while tick_stall is low; its sample passes the phase
// and ROM read, the amplitude multiply and the output register in turn. The three
// stages advance independently, so a stalled sample only stops the ticks
// once the pipeline is full. rst is synchronous, clears the phase and all
// valids, and sets the registers to their reset values. No clearing pass.
// ---------------------------------------------------------------------------
module multi_shape_waveform_generator #(
  parameter int PHASE_BITS      = mswg_pkg::DEF_PHASE_BITS,
  parameter int SINE_TABLE_BITS = mswg_pkg::DEF_SINE_TABLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mswg_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // tick items
  input  logic                                 tick_valid,
  output logic                                 tick_stall,
  input  logic                                 restart,
  // sample items
  output logic                                 sample_valid,
  input  logic                                 sample_stall,
  output logic signed [mswg_pkg::SAMPLE_W-1:0] sample
);
  import mswg_pkg::*;

  logic [31:0]                phase_step;
  logic [AMP_W-1:0]           amplitude;
  logic [1:0]                 wave_shape;
  logic                       cfg_wr;
  logic [1:0]                 reg_idx;

  logic                       s1_valid;
  logic                       s2_valid;
  logic                       out_free;
  logic                       s2_free;
  logic                       s1_free;
  logic                       tick_acc;
  logic                       s2_load;
  logic                       out_load;

  logic [SINE_TABLE_BITS:0]   rom_addr;
  logic [TAB_W-1:0]           rom_data;
  logic [31:0]                s1_p32;
  prod_t                      prod;
  logic [SAMPLE_W-1:0]        mag_s;
  logic [SAMPLE_W-1:0]        sat_s;

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= RST_PHASE_STEP;
      amplitude  <= RST_AMPLITUDE;
      wave_shape <= RST_WAVE_SHAPE;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PHASE_STEP: phase_step <= pwdata;
        REG_AMPLITUDE:  amplitude  <= pwdata[AMP_W-1:0];
        REG_WAVE_SHAPE: wave_shape <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PHASE_STEP: prdata = phase_step;
      REG_AMPLITUDE:  prdata = 32'(amplitude);
      REG_WAVE_SHAPE: prdata = 32'(wave_shape);
      default:        prdata = '0;
    endcase
  end

  // Pipeline flow: a stage loads when it is empty or its item moves on
  assign out_free   = !sample_valid || !sample_stall;
  assign s2_free    = !s2_valid || out_free;
  assign s1_free    = !s1_valid || s2_free;
  assign tick_stall = !s1_free;
  assign tick_acc   = tick_valid && s1_free;
  assign s2_load    = s1_valid && s2_free;
  assign out_load   = s2_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      sample_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= tick_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        sample_valid <= s2_valid;
      end
    end
  end

  // Stage 1: phase and ROM read
  mswg_phase #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_phase (
    .clk        (clk),
    .rst        (rst),
    .accept     (tick_acc),
    .restart    (restart),
    .phase_step (phase_step),
    .rom_addr   (rom_addr),
    .p32        (s1_p32)
  );

  mswg_sine_rom #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk  (clk),
    .en   (tick_acc),
    .addr (rom_addr),
    .data (rom_data)
  );

  // Stage 2: shape and amplitude product
  mswg_shape u_shape (
    .clk        (clk),
    .load       (s2_load),
    .p32        (s1_p32),
    .rom_data   (rom_data),
    .wave_shape (wave_shape),
    .amplitude  (amplitude),
    .prod       (prod)
  );

  // Output: truncate toward zero (magnitude floor), saturate, apply sign
  assign mag_s = prod.mag[32 +: SAMPLE_W];
  assign sat_s = (32'(mag_s) > SAMPLE_LIMIT) ? SAMPLE_LIMIT[SAMPLE_W-1:0] : mag_s;

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample <= prod.neg ? -sat_s : sat_s;
    end
  end

  // Restart puts a zero phase into stage 1
  a_restart_zero: assert property (@(posedge clk) disable iff (rst)
    tick_acc && restart |=> s1_p32 == 32'd0)
    else $error("restart did not zero the stage-1 phase");

  // A blocked stage-1 item keeps its phase
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_free |=> s1_valid && $stable(s1_p32))
    else $error("stage-1 item lost while blocked");

  // A stage-2 item moving out shows up as a sample
  a_s2_to_out: assert property (@(posedge clk) disable iff (rst)
    out_load |=> sample_valid)
    else $error("stage-2 item did not reach the output");

endmodule

// ===== sv/mswg_sine_rom.sv =====
// ---------------------------------------------------------------------------
// mswg_sine_rom
// Quarter-wave sine ROM, 2^SINE_TABLE_BITS + 1 entries, registered read.
// ---------------------------------------------------------------------------
module mswg_sine_rom #(
  parameter int SINE_TABLE_BITS = mswg_pkg::DEF_SINE_TABLE_BITS
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [SINE_TABLE_BITS:0]     addr,
  output logic [mswg_pkg::TAB_W-1:0]   data
);
  import mswg_pkg::*;

  localparam int DEPTH = (1 << SINE_TABLE_BITS) + 1;

  logic [TAB_W-1:0] rom [DEPTH];

  // Contents fixed at elaboration
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_rom
    assign rom[gi] = sine_entry(gi, SINE_TABLE_BITS);
  end

  // Registered read, held while the stage is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom[addr];
    end
  end

endmodule

// ===== sv/mswg_phase.sv =====
// ---------------------------------------------------------------------------
// mswg_phase
// Phase accumulator. Produces the 32-bit aligned phase for the accepted
// item, the sine ROM address, and the stage-1 phase register.
// ---------------------------------------------------------------------------
module mswg_phase #(
  parameter int PHASE_BITS      = mswg_pkg::DEF_PHASE_BITS,
  parameter int SINE_TABLE_BITS = mswg_pkg::DEF_SINE_TABLE_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic                     restart,
  input  logic [31:0]              phase_step,
  output logic [SINE_TABLE_BITS:0] rom_addr,
  output logic [31:0]              p32
);
  import mswg_pkg::*;

  localparam int AW = SINE_TABLE_BITS + 1;

  logic [PHASE_BITS-1:0]      phase;
  logic [PHASE_BITS-1:0]      phase_cur;
  logic [PHASE_BITS-1:0]      step;
  logic [31:0]                p32_cur;
  logic [SINE_TABLE_BITS-1:0] k;

  // Restart zeroes the phase before this item's sample
  assign phase_cur = restart ? '0 : phase;

  // Align phase and step between PHASE_BITS and the 0.32 format
  if (PHASE_BITS >= 32) begin : g_wide
    localparam int SH = PHASE_BITS - 32;
    assign step    = PHASE_BITS'(phase_step) << SH;
    assign p32_cur = 32'(phase_cur >> SH);
  end else begin : g_narrow
    localparam int SH = 32 - PHASE_BITS;
    assign step    = PHASE_BITS'(phase_step >> SH);
    assign p32_cur = 32'(phase_cur) << SH;
  end

  // Quadrant 1 and 3 read the table mirrored
  assign k        = p32_cur[29 -: SINE_TABLE_BITS];
  assign rom_addr = p32_cur[30] ? ((AW'(1) << SINE_TABLE_BITS) - {1'b0, k}) : {1'b0, k};

  // Accumulator, wraps modulo one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (accept) begin
      phase <= phase_cur + step;
    end
  end

  // Stage-1 phase
  always_ff @(posedge clk) begin
    if (accept) begin
      p32 <= p32_cur;
    end
  end

endmodule

// ===== sv/mswg_shape.sv =====
// ---------------------------------------------------------------------------
// mswg_shape
// Builds the signed Q1.32 shape value as sign and magnitude and scales it
// by the amplitude; the product is registered.
// ---------------------------------------------------------------------------
module mswg_shape (
  input  logic                       clk,
  input  logic                       load,
  input  logic [31:0]                p32,
  input  logic [mswg_pkg::TAB_W-1:0] rom_data,
  input  logic [1:0]                 wave_shape,
  input  logic [mswg_pkg::AMP_W-1:0] amplitude,
  output mswg_pkg::prod_t            prod
);
  import mswg_pkg::*;

  localparam logic [MAG_W-1:0] ONE = MAG_W'(1) << 32;

  logic [MAG_W-1:0] mag;
  logic             neg;
  logic [MAG_W-1:0] r_saw;
  logic [MAG_W-1:0] r_tri;

  assign r_saw = {1'b0, p32[30:0], 1'b0};
  assign r_tri = {1'b0, p32[29:0], 2'b00};

  // Sign and magnitude per shape
  always_comb begin
    case (wave_shape)
      SHAPE_SQUARE: begin
        mag = ONE;
        neg = p32[31];
      end
      SHAPE_SAWTOOTH: begin
        mag = p32[31] ? r_saw : ONE - r_saw;
        neg = ~p32[31];
      end
      SHAPE_TRIANGLE: begin
        mag = p32[30] ? r_tri : ONE - r_tri;
        neg = ~(p32[31] ^ p32[30]);
      end
      default: begin
        // sine: Q1.15 table value moved to Q1.32
        mag = {1'b0, rom_data, 17'b0};
        neg = p32[31];
      end
    endcase
  end

  // Scale by amplitude
  always_ff @(posedge clk) begin
    if (load) begin
      prod.mag <= PROD_W'(mag) * PROD_W'(amplitude);
      prod.neg <= neg;
    end
  end

endmodule

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Testbench for multi_shape_waveform_generator. Tick items with a random
// restart bit go in through a queued driver, the samples that come back are
// checked against a local phase-accumulator model of all four wave shapes.
// Registers are set through the APB port between bursts while the block is
// idle, and read back.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mswg_pkg::*;

  // Register index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Values the registers hold after reset
  localparam logic [31:0] INIT_STEP  = 32'd4869566;
  localparam logic [14:0] INIT_AMP   = 15'd30000;
  localparam logic [1:0]  INIT_SHAPE = SHAPE_SINE;

  // Sine table geometry and fixed-point constants
  localparam int              QTR_BITS      = 10;
  localparam int              QTR_SIZE      = 1 << QTR_BITS;
  localparam longint unsigned QTR_ANGLE_Q30 = 64'd1686629713;
  localparam longint          ONE_CYCLE     = 64'sh1_0000_0000;
  localparam longint          SAT_MAX       = 64'sd32767;

  localparam int DIRECTED_ITEMS = 23;
  localparam int RANDOM_ITEMS   = 400;
  localparam int STALL_LIMIT    = 2000;

  typedef struct {
    logic restart;
    int   gap;
  } tick_item_t;

  // Block ports
  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [ADDR_W-1:0]   paddr        = '0;
  logic [31:0]         pwdata       = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                tick_valid   = 1'b0;
  logic                tick_stall;
  logic                restart      = 1'b0;
  logic                sample_valid;
  logic                sample_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;

  // Local copy of the block state
  int          quarter_sine [0:QTR_SIZE];
  logic [31:0] phase_acc;
  logic [31:0] step_r;
  logic [14:0] amp_r;
  logic [1:0]  shape_r;

  // Traffic bookkeeping
  tick_item_t        tick_q[$];
  tick_item_t        next_tick;
  bit                holding      = 1'b0;
  logic [SAMPLE_W-1:0] sample_expect[$];
  bit                tick_fire    = 1'b0;
  bit                sample_fire  = 1'b0;
  bit                quiet        = 1'b0;
  int                stall_left   = 5;
  int                idle_cycles  = 0;
  int unsigned       ticks_queued = 0;
  int unsigned       ticks_taken  = 0;
  int unsigned       samples_seen = 0;
  int unsigned       restarts     = 0;
  int unsigned       settings     = 0;
  int unsigned       mismatches   = 0;
  int unsigned       shape_hits [4];

  multi_shape_waveform_generator DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .restart      (restart),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Quarter-wave entry in Q1.15: Taylor series for sin in Q30, rounded
  function automatic int quarter_entry(input int unsigned idx);
    longint unsigned ang;
    longint unsigned pw;
    longint          acc;
    longint          r;
    ang = (QTR_ANGLE_Q30 * idx) >> QTR_BITS;
    pw  = ang;
    acc = ang;
    for (int n = 1; n <= 8; n++) begin
      pw = (pw * ang) >> 30;
      pw = (pw * ang) >> 30;
      pw = pw / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(pw);
      end else begin
        acc = acc + longint'(pw);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = (acc + 64'sd16384) >>> 15;
    if (r > SAT_MAX) begin
      r = SAT_MAX;
    end
    return int'(r);
  endfunction

  // Sample for one tick item; advances the phase afterwards
  function automatic logic [SAMPLE_W-1:0] next_sample(input logic rs);
    logic [31:0] p;
    logic [1:0]  quad;
    logic [9:0]  k;
    longint      a;
    longint      v;
    longint      n;
    longint      s;
    if (rs) begin
      phase_acc = '0;
    end
    p = phase_acc;
    a = amp_r;
    case (shape_r)
      SHAPE_SINE: begin
        quad = p[31:30];
        k    = p[29:20];
        v    = quad[0] ? quarter_sine[QTR_SIZE - k] : quarter_sine[k];
        if (quad[1]) begin
          v = -v;
        end
        s = (v * a) / 64'sd32768;
      end
      SHAPE_SQUARE: begin
        s = p[31] ? -a : a;
      end
      SHAPE_SAWTOOTH: begin
        n = 2 * longint'(p) - ONE_CYCLE;
        s = (n * a) / ONE_CYCLE;
      end
      default: begin
        if (!p[31]) begin
          n = 4 * longint'(p) - ONE_CYCLE;
        end else begin
          n = 3 * ONE_CYCLE - 4 * longint'(p);
        end
        s = (n * a) / ONE_CYCLE;
      end
    endcase
    if (s > SAT_MAX) begin
      s = SAT_MAX;
    end
    if (s < -SAT_MAX) begin
      s = -SAT_MAX;
    end
    shape_hits[shape_r]++;
    phase_acc = phase_acc + step_r;
    return s[SAMPLE_W-1:0];
  endfunction

  // Half the items go back to back, the rest wait a random gap; none wait while quiet
  function automatic int pick_wait();
    if (quiet || $urandom_range(0, 1) == 0) begin
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%t mismatch, %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_cycle(input logic wr, input logic [1:0] idx,
                           input logic [31:0] data, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write a register, mirror it in the model, read it back unless the index is unused
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    logic [31:0] want;
    logic [31:0] got;
    apb_cycle(1'b1, idx, data, got);
    case (idx)
      REG_PHASE_STEP: begin
        step_r = data;
        want   = step_r;
      end
      REG_AMPLITUDE: begin
        amp_r = data[AMP_W-1:0];
        want  = 32'(amp_r);
      end
      REG_WAVE_SHAPE: begin
        shape_r = data[1:0];
        want    = 32'(shape_r);
      end
      default: want = 'x;
    endcase
    if (idx != REG_UNUSED) begin
      apb_cycle(1'b0, idx, 32'h0, got);
      if (got !== want) begin
        note_mismatch($sformatf("readback of register %0d", idx), want, got);
      end
    end
  endtask

  task automatic push_tick(input logic rs);
    tick_item_t it;
    it.restart = rs;
    it.gap     = pick_wait();
    tick_q.push_back(it);
    ticks_queued++;
    if (rs) begin
      restarts++;
    end
  endtask

  // Hold off until every queued tick is taken and every sample is back
  task automatic drain();
    do begin
      @(negedge clk);
    end while (ticks_taken != ticks_queued || sample_expect.size() != 0);
  endtask

  // Tick driver: optional gap, then hold the item until it is taken
  always @(negedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (!tick_valid || tick_fire) begin
      if (!holding && tick_q.size() != 0) begin
        next_tick = tick_q.pop_front();
        holding   = 1'b1;
      end
      if (holding && next_tick.gap == 0) begin
        tick_valid <= 1'b1;
        restart    <= next_tick.restart;
        holding     = 1'b0;
      end else begin
        tick_valid <= 1'b0;
        if (holding) begin
          next_tick.gap--;
        end
      end
    end
  end

  // Sample receiver: random stall ahead of each sample item
  always @(negedge clk) begin
    if (rst) begin
      sample_stall <= 1'b0;
    end else begin
      if (sample_fire) begin
        stall_left = pick_wait();
      end
      if (stall_left != 0) begin
        sample_stall <= 1'b1;
        stall_left--;
      end else begin
        sample_stall <= 1'b0;
      end
    end
  end

  // Monitor: predict on tick accept, check on sample accept, watchdog
  always @(posedge clk) begin
    tick_fire   = !rst && tick_valid && !tick_stall;
    sample_fire = !rst && sample_valid && !sample_stall;
    if (sample_fire) begin
      samples_seen++;
      if (sample_expect.size() == 0) begin
        note_mismatch("sample with none expected", 'x, 32'(sample));
      end else if (sample !== sample_expect[0]) begin
        note_mismatch("sample", 32'(sample_expect[0]), 32'(sample));
        void'(sample_expect.pop_front());
      end else begin
        void'(sample_expect.pop_front());
      end
    end
    if (tick_fire) begin
      ticks_taken++;
      sample_expect.push_back(next_sample(restart));
    end
    if (tick_fire || sample_fire) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: %0d cycles without a handshake, %0d samples outstanding",
               idle_cycles, sample_expect.size());
      $display("[multi_shape_waveform_generator] ERROR");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    logic [31:0] wdata;
    for (int i = 0; i <= QTR_SIZE; i++) begin
      quarter_sine[i] = quarter_entry(i);
    end
    phase_acc = '0;
    step_r    = INIT_STEP;
    amp_r     = INIT_AMP;
    shape_r   = INIT_SHAPE;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings, sine at the default step
    settings++;
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b0);
    drain();

    // Quarter-cycle step lands on every quadrant edge; amplitude at its top,
    // written with junk above the field
    write_reg(REG_PHASE_STEP, 32'h4000_0000);
    write_reg(REG_AMPLITUDE, 32'hFFFF_FFFF);
    for (int sh = 0; sh < 4; sh++) begin
      write_reg(REG_WAVE_SHAPE, 32'hFFFF_FFFC | 32'(sh));
      settings++;
      push_tick(1'b1);
      repeat (3) push_tick(1'b0);
      drain();
    end

    // Write to the hole in the map must change nothing; zero amplitude
    write_reg(REG_UNUSED, 32'h0000_0000);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_AMPLITUDE, 32'h0000_8000);
    write_reg(REG_WAVE_SHAPE, 32'(SHAPE_SAWTOOTH));
    settings++;
    push_tick(1'b1);
    push_tick(1'b0);
    drain();

    // Largest step: second tick sits on the last phase before wrap
    write_reg(REG_AMPLITUDE, 32'h0000_7FFF);
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(REG_WAVE_SHAPE, 32'(SHAPE_TRIANGLE));
    settings++;
    push_tick(1'b1);
    push_tick(1'b0);
    drain();

    // Random bursts, each under its own register settings
    while (ticks_queued < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 3))
          0, 1: wdata = $urandom();
          2: wdata = $urandom_range(1, 32'h0100_0000);
          default: begin
            case ($urandom_range(0, 3))
              0: wdata = 32'h0000_0000;
              1: wdata = 32'h8000_0000;
              2: wdata = 32'hFFFF_FFFF;
              default: wdata = 32'h0000_0001;
            endcase
          end
        endcase
        write_reg(REG_PHASE_STEP, wdata);
      end
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 3))
          0: wdata = 32'h0;
          1: wdata = 32'h7FFF;
          default: wdata = $urandom_range(0, 32'h7FFF);
        endcase
        if ($urandom_range(0, 1) == 1) begin
          wdata = wdata | ($urandom() & 32'hFFFF_8000);
        end
        write_reg(REG_AMPLITUDE, wdata);
      end
      if ($urandom_range(0, 9) < 7) begin
        wdata = $urandom_range(0, 3);
        if ($urandom_range(0, 1) == 1) begin
          wdata = wdata | ($urandom() & 32'hFFFF_FFFC);
        end
        write_reg(REG_WAVE_SHAPE, wdata);
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(REG_UNUSED, $urandom());
      end
      settings++;
      repeat ($urandom_range(15, 60)) push_tick($urandom_range(0, 15) == 0);
      drain();
    end

    // Let any stray sample show up before calling it
    quiet = 1'b1;
    repeat (10) @(posedge clk);

    $display("Sent %0d tick items (%0d with restart) under %0d register settings.",
             ticks_taken, restarts, settings);
    $display("Checked %0d samples: sine %0d, square %0d, sawtooth %0d, triangle %0d.",
             samples_seen, shape_hits[SHAPE_SINE], shape_hits[SHAPE_SQUARE],
             shape_hits[SHAPE_SAWTOOTH], shape_hits[SHAPE_TRIANGLE]);
    if (mismatches == 0) begin
      $display("[multi_shape_waveform_generator] OK");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("[multi_shape_waveform_generator] ERROR");
    end
    $finish;
  end

endmodule
